// ===== sv/assert_macros.svh =====
// Assertion helpers shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property checked on every rising edge while out of reset.
`define AIMD_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("assertion failed");

// Condition that must never hold while out of reset.
`define AIMD_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
    else $error("forbidden condition");

`else

`define AIMD_ASSERT(lbl, clk, rstn, prop)
`define AIMD_NEVER(lbl, clk, rstn, cond)

`endif

`endif

// ===== sv/aimd_pkg.sv =====
`timescale 1ns / 1ps

package aimd_pkg;

  localparam int RAW_WIDTH       = 16;
  localparam int SCALE_WIDTH_DEF = 8;
  localparam int SCALE_KEEP_BITS = 8;
  localparam int AXIS_W          = 20;
  localparam int MAG_W           = 20;
  localparam int THR_W           = 20;
  localparam int RES_W           = 4;
  localparam int SHIFT_W         = 4;
  localparam int NUM_AXES        = 3;
  localparam int AXIS_IDX_W      = 2;
  localparam int MUL_W           = 20;
  localparam int PROD_W          = 2 * MUL_W;
  localparam int SUM_W           = 40;
  localparam int ROOT_STEPS      = SUM_W / 2;
  localparam int CNT_W           = 5;
  localparam int CFG_ADDR_W      = 2;
  localparam int CFG_DATA_W      = 20;

  localparam int RES_MIN         = 8;
  localparam int RES_MAX         = 12;
  localparam int RES_RESET       = 10;
  localparam int SCALE_RESET     = 48;
  localparam int THR_RESET       = 2000;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_RESOLUTION = 2'd0,
    REG_SCALE      = 2'd1,
    REG_THRESHOLD  = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCALE,
    ST_SQUARE,
    ST_ROOT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic                  load;
    logic                  scale;
    logic                  square;
    logic                  root;
    logic                  publish;
    logic [AXIS_IDX_W-1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } stat_t;

endpackage

// ===== sv/aimd_ctrl.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module aimd_ctrl
  import aimd_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_tvalid,
  output logic  in_tready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;

  localparam logic [CNT_W-1:0] AxisLast = CNT_W'(NUM_AXES - 1);
  localparam logic [CNT_W-1:0] RootLast = CNT_W'(ROOT_STEPS - 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        cnt_nxt = '0;
        if (in_tvalid) state_nxt = ST_SCALE;
      end
      ST_SCALE: begin
        if (cnt_r == AxisLast) begin
          state_nxt = ST_SQUARE;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_SQUARE: begin
        if (cnt_r == AxisLast) begin
          state_nxt = ST_ROOT;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_ROOT: begin
        if (cnt_r == RootLast) begin
          state_nxt = ST_DONE;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_DONE: begin
        if (stat.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    cmd.idx   = cnt_r[AXIS_IDX_W-1:0];
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      ST_SCALE:  cmd.scale   = 1'b1;
      ST_SQUARE: cmd.square  = 1'b1;
      ST_ROOT:   cmd.root    = 1'b1;
      ST_DONE:   cmd.publish = stat.out_free;
      default:   cmd         = '0;
    endcase
  end

  `AIMD_ASSERT(a_load_starts_scale, clk, rst_n, cmd.load |=> state_r == ST_SCALE)
  `AIMD_NEVER(a_axis_cnt_range, clk, rst_n,
              (state_r == ST_SCALE || state_r == ST_SQUARE) && cnt_r > AxisLast)
  `AIMD_ASSERT(a_root_done, clk, rst_n,
               (state_r == ST_ROOT && cnt_r == RootLast) |=> state_r == ST_DONE)

endmodule

// ===== sv/aimd_dp.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module aimd_dp
  import aimd_pkg::*;
#(
  parameter int SCALE_WIDTH = SCALE_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  cmd_t                         cmd,
  output stat_t                        stat,
  input  logic [NUM_AXES*RAW_WIDTH-1:0] in_tdata,
  input  logic                         in_tlast,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [CFG_ADDR_W-1:0]        cfg_addr,
  input  logic [CFG_DATA_W-1:0]        cfg_data,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [(NUM_AXES*AXIS_W+MAG_W)-1:0] out_tdata,
  output logic [1:0]                   out_tuser,
  output logic                         out_tlast
);

  localparam int REM_W = MAG_W + 3;
  localparam logic signed [PROD_W-1:0] SatHi = PROD_W'((1 << (AXIS_W - 1)) - 1);
  localparam logic signed [PROD_W-1:0] SatLo = -PROD_W'(1 << (AXIS_W - 1));
  localparam logic [SCALE_WIDTH-1:0]  ScaleKeep = SCALE_WIDTH'((1 << SCALE_KEEP_BITS) - 1);

  // Configuration registers
  logic [RES_W-1:0]       res_r;
  logic [SCALE_WIDTH-1:0] scale_r;
  logic [THR_W-1:0]       thr_r;

  // Working registers
  logic signed [RAW_WIDTH-1:0] raw_r  [NUM_AXES];
  logic signed [AXIS_W-1:0]    axis_r [NUM_AXES];
  logic                        last_in_r;
  logic [SUM_W-1:0]            rad_r;
  logic [REM_W-1:0]            rem_r;
  logic [MAG_W-1:0]            root_r;
  logic                        seen_r;

  // Output register
  logic                        out_valid_r, out_valid_nxt;
  logic [AXIS_W-1:0]           ox_r, oy_r, oz_r;
  logic [MAG_W-1:0]            mag_r;
  logic                        over_r, bimp_r, last_r;

  logic [RES_W-1:0]            res_clamp;
  logic [SHIFT_W-1:0]          shift;
  logic signed [RAW_WIDTH-1:0] shifted;
  logic signed [MUL_W-1:0]     mul_a, mul_b;
  logic signed [PROD_W-1:0]    prod;
  logic signed [AXIS_W-1:0]    sat;
  logic [REM_W-1:0]            rem_sh, trial;
  logic                        fits;
  logic                        over;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r   <= RES_W'(RES_RESET);
      scale_r <= SCALE_WIDTH'(SCALE_RESET);
      thr_r   <= THR_W'(THR_RESET);
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_RESOLUTION: res_r   <= cfg_data[RES_W-1:0];
        REG_SCALE:      scale_r <= SCALE_WIDTH'(cfg_data) & ScaleKeep;
        REG_THRESHOLD:  thr_r   <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Resolution outside the supported range is clamped before the shift.
  always_comb begin
    if (res_r < RES_W'(RES_MIN))      res_clamp = RES_W'(RES_MIN);
    else if (res_r > RES_W'(RES_MAX)) res_clamp = RES_W'(RES_MAX);
    else                              res_clamp = res_r;
    shift = SHIFT_W'(RAW_WIDTH) - SHIFT_W'(res_clamp);
  end

  assign shifted = raw_r[cmd.idx] >>> shift;

  // One shared multiplier: scaling in the first pass, squaring in the second.
  always_comb begin
    if (cmd.square) begin
      mul_a = MUL_W'(axis_r[cmd.idx]);
      mul_b = MUL_W'(axis_r[cmd.idx]);
    end else begin
      mul_a = MUL_W'(shifted);
      mul_b = $signed(MUL_W'({1'b0, scale_r}));
    end
  end

  assign prod = mul_a * mul_b;

  always_comb begin
    if (prod > SatHi)      sat = AXIS_W'(SatHi);
    else if (prod < SatLo) sat = AXIS_W'(SatLo);
    else                   sat = prod[AXIS_W-1:0];
  end

  // Restoring square root, one result bit per step.
  assign rem_sh = {rem_r[REM_W-3:0], rad_r[SUM_W-1 -: 2]};
  assign trial  = REM_W'({root_r, 2'b01});
  assign fits   = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      raw_r[0]  <= in_tdata[0*RAW_WIDTH +: RAW_WIDTH];
      raw_r[1]  <= in_tdata[1*RAW_WIDTH +: RAW_WIDTH];
      raw_r[2]  <= in_tdata[2*RAW_WIDTH +: RAW_WIDTH];
      last_in_r <= in_tlast;
      rad_r     <= '0;
      rem_r     <= '0;
      root_r    <= '0;
    end
    if (cmd.scale) axis_r[cmd.idx] <= sat;
    if (cmd.square) rad_r <= rad_r + SUM_W'($unsigned(prod));
    if (cmd.root) begin
      rad_r  <= {rad_r[SUM_W-3:0], 2'b00};
      rem_r  <= fits ? rem_sh - trial : rem_sh;
      root_r <= {root_r[MAG_W-2:0], fits};
    end
  end

  assign over = root_r > MAG_W'(thr_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= 1'b0;
    end else if (cmd.publish) begin
      if (last_in_r)  seen_r <= 1'b0;
      else if (over)  seen_r <= 1'b1;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.publish)     out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= out_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      ox_r   <= axis_r[0];
      oy_r   <= axis_r[1];
      oz_r   <= axis_r[2];
      mag_r  <= root_r;
      over_r <= over;
      bimp_r <= last_in_r && (seen_r || over);
      last_r <= last_in_r;
    end
  end

  assign stat.out_free = !out_valid_r || out_tready;
  assign out_tvalid    = out_valid_r;
  assign out_tdata     = {mag_r, oz_r, oy_r, ox_r};
  assign out_tuser     = {bimp_r, over_r};
  assign out_tlast     = last_r;

  `AIMD_ASSERT(a_publish_shows, clk, rst_n, cmd.publish |=> out_valid_r)
  `AIMD_NEVER(a_bimp_only_last, clk, rst_n, out_valid_r && !last_r && bimp_r)
  `AIMD_NEVER(a_publish_overwrite, clk, rst_n, cmd.publish && out_valid_r && !out_tready)

endmodule

// ===== sv/accel_impact_magnitude_detector.sv =====
`timescale 1ns / 1ps
// Channel  Direction  Handshake            Payload
// in       slave      in_tvalid/in_tready  tdata: raw_x, raw_y, raw_z; tlast: batch_end
// out      master     out_tvalid/out_tready tdata: accel_x/y/z, magnitude;
//                                          tuser: over_threshold, batch_impact; tlast: last
// cfg      slave      cfg_valid/cfg_ready  cfg_addr: register index; cfg_data: value
//
// A sample is taken in a load cycle and goes through the scale, square, root and done states:
// the three axes are scaled, then squared on one shared multiplier, the one-bit-per-step
// square root runs and the done state publishes into the output register. A return to idle
// follows, so a new sample is taken only once the last is published, even while its result
// still waits; a stalled output holds the block in its final state.
// rst_n is synchronous and active low; it restores the defaults and clears the batch flag.

module accel_impact_magnitude_detector
  import aimd_pkg::*;
#(
  parameter int SCALE_WIDTH = SCALE_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // raw_x [15:0], raw_y [31:16], raw_z [47:32]
  input  logic [NUM_AXES*RAW_WIDTH-1:0]       in_tdata,
  input  logic                                in_tlast,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [CFG_ADDR_W-1:0]               cfg_addr,
  input  logic [CFG_DATA_W-1:0]               cfg_data,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // accel_x [19:0], accel_y [39:20], accel_z [59:40], magnitude [79:60]
  output logic [(NUM_AXES*AXIS_W+MAG_W)-1:0]  out_tdata,
  // over_threshold [0], batch_impact [1]
  output logic [1:0]                          out_tuser,
  output logic                                out_tlast
);

  cmd_t  cmd;
  stat_t stat;

  aimd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  aimd_dp #(
    .SCALE_WIDTH (SCALE_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== dv/accel_impact_magnitude_detector_tb.sv =====
`timescale 1ns / 1ps

module accel_impact_magnitude_detector_tb;
  import aimd_pkg::*;

  localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 2'd3;
  localparam longint AXIS_MAX_V    = (longint'(1) <<< (AXIS_W - 1)) - 1;
  localparam longint AXIS_MIN_V    = -(longint'(1) <<< (AXIS_W - 1));
  localparam int     SETTLE_CYCLES = 40;
  localparam int     HOLD_CYCLES   = 300;
  localparam int     STALL_LIMIT   = 4000;
  localparam int     NUM_PHASES    = 8;
  localparam int     PHASE_ITEMS   = 205;

  typedef struct packed {
    logic signed [RAW_WIDTH-1:0] raw_x;
    logic signed [RAW_WIDTH-1:0] raw_y;
    logic signed [RAW_WIDTH-1:0] raw_z;
    logic                        batch_end;
  } sample_t;

  typedef struct packed {
    logic signed [AXIS_W-1:0] accel_x;
    logic signed [AXIS_W-1:0] accel_y;
    logic signed [AXIS_W-1:0] accel_z;
    logic [MAG_W-1:0]         magnitude;
    logic                     over_threshold;
    logic                     batch_impact;
    logic                     last_flag;
  } result_t;

  logic                               clk        = 1'b0;
  logic                               rst_n      = 1'b0;
  logic                               in_tvalid  = 1'b0;
  logic                               in_tready;
  logic [NUM_AXES*RAW_WIDTH-1:0]      in_tdata   = '0;
  logic                               in_tlast   = 1'b0;
  logic                               cfg_valid  = 1'b0;
  logic                               cfg_ready;
  logic [CFG_ADDR_W-1:0]              cfg_addr   = '0;
  logic [CFG_DATA_W-1:0]              cfg_data   = '0;
  logic                               out_tvalid;
  logic                               out_tready = 1'b0;
  logic [(NUM_AXES*AXIS_W+MAG_W)-1:0] out_tdata;
  logic [1:0]                         out_tuser;
  logic                               out_tlast;

  // Shadow copy of the block's registers and its open-batch flag.
  logic [RES_W-1:0]           res_reg   = RES_W'(RES_RESET);
  logic [SCALE_KEEP_BITS-1:0] scale_reg = SCALE_KEEP_BITS'(SCALE_RESET);
  logic [THR_W-1:0]           thr_reg   = THR_W'(THR_RESET);
  logic                       batch_hit = 1'b0;

  sample_t     sample_q[$];
  result_t     result_q[$];
  sample_t     cur_smp;
  result_t     want_r;
  result_t     got_r;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  logic        hold_armed     = 1'b0;
  int          hold_cnt;
  int          stall_cycles;
  int          mismatch_cnt   = 0;
  int          sample_cnt     = 0;
  int          result_cnt     = 0;
  int          batch_cnt      = 0;
  int          impact_cnt     = 0;
  int          cfg_writes     = 0;
  int          setting_cnt    = 0;

  accel_impact_magnitude_detector #(
    .SCALE_WIDTH(SCALE_WIDTH_DEF)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int unsigned clamp_res(input logic [RES_W-1:0] r);
    if (r < RES_MIN) return RES_MIN;
    if (r > RES_MAX) return RES_MAX;
    return r;
  endfunction

  // Floor square root, one result bit at a time from the top.
  function automatic logic [MAG_W-1:0] floor_root(input longint unsigned n);
    logic [MAG_W-1:0] root;
    longint unsigned  trial;
    root = '0;
    for (int b = MAG_W - 1; b >= 0; b--) begin
      trial = root | (MAG_W'(1) << b);
      if (trial * trial <= n) root = trial[MAG_W-1:0];
    end
    return root;
  endfunction

  task automatic predict_sample(input sample_t s, output result_t r);
    logic signed [RAW_WIDTH-1:0] raw[NUM_AXES];
    logic signed [AXIS_W-1:0]    scaled[NUM_AXES];
    int unsigned                 shift;
    longint                      acc;
    longint unsigned             sum;
    shift  = RAW_WIDTH - clamp_res(res_reg);
    raw[0] = s.raw_x;
    raw[1] = s.raw_y;
    raw[2] = s.raw_z;
    sum    = 0;
    for (int i = 0; i < NUM_AXES; i++) begin
      acc = (longint'(raw[i]) >>> shift) * longint'(scale_reg);
      if (acc > AXIS_MAX_V) acc = AXIS_MAX_V;
      if (acc < AXIS_MIN_V) acc = AXIS_MIN_V;
      scaled[i] = acc[AXIS_W-1:0];
      sum += acc * acc;
    end
    r.accel_x        = scaled[0];
    r.accel_y        = scaled[1];
    r.accel_z        = scaled[2];
    r.magnitude      = floor_root(sum);
    r.over_threshold = (r.magnitude > thr_reg);
    r.last_flag      = s.batch_end;
    if (s.batch_end) begin
      r.batch_impact = batch_hit | r.over_threshold;
      batch_hit      = 1'b0;
    end else begin
      r.batch_impact = 1'b0;
      if (r.over_threshold) batch_hit = 1'b1;
    end
  endtask

  function automatic sample_t make_sample(input int x, input int y, input int z, input bit e);
    sample_t s;
    s.raw_x     = x[RAW_WIDTH-1:0];
    s.raw_y     = y[RAW_WIDTH-1:0];
    s.raw_z     = z[RAW_WIDTH-1:0];
    s.batch_end = e;
    return s;
  endfunction

  // Mix of full-range, near-zero and extreme readings per axis.
  function automatic sample_t rand_sample();
    logic signed [RAW_WIDTH-1:0] ax[NUM_AXES];
    int unsigned                 kind;
    for (int i = 0; i < NUM_AXES; i++) begin
      kind = $urandom_range(0, 9);
      if (kind < 5) begin
        ax[i] = RAW_WIDTH'($urandom);
      end else if (kind < 9) begin
        ax[i] = RAW_WIDTH'($urandom_range(0, 4095)) - RAW_WIDTH'(2048);
      end else begin
        case ($urandom_range(0, 3))
          0:       ax[i] = 16'sh8000;
          1:       ax[i] = 16'sh7FFF;
          2:       ax[i] = '0;
          default: ax[i] = '1;
        endcase
      end
    end
    return make_sample(ax[0], ax[1], ax[2], $urandom_range(0, 4) == 0);
  endfunction

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_addr  <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cfg_writes++;
    case (idx)
      REG_RESOLUTION: res_reg   = val[RES_W-1:0];
      REG_SCALE:      scale_reg = val[SCALE_KEEP_BITS-1:0];
      REG_THRESHOLD:  thr_reg   = val[THR_W-1:0];
      default: ;
    endcase
  endtask

  // Bits above each register's width carry random junk that must be dropped.
  task automatic apply_settings(input int unsigned res, input int unsigned scl,
                                input int unsigned thr);
    logic [CFG_DATA_W-1:0] val;
    val = CFG_DATA_W'($urandom);
    val[RES_W-1:0] = res[RES_W-1:0];
    write_reg(REG_RESOLUTION, val);
    val = CFG_DATA_W'($urandom);
    val[SCALE_KEEP_BITS-1:0] = scl[SCALE_KEEP_BITS-1:0];
    write_reg(REG_SCALE, val);
    write_reg(REG_THRESHOLD, thr[THR_W-1:0]);
    setting_cnt++;
  endtask

  task automatic wait_idle();
    while (sample_q.size() != 0 || in_tvalid || result_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Request source: holds the current request until the block takes it.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_sample(cur_smp, want_r);
        result_q.push_back(want_r);
        sample_cnt++;
      end
      if (!in_tvalid || in_tready) begin
        if (sample_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          cur_smp = sample_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {cur_smp.raw_z, cur_smp.raw_y, cur_smp.raw_x};
          in_tlast  <= cur_smp.batch_end;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_cnt   <= 0;
    end else if (hold_armed && hold_cnt < HOLD_CYCLES) begin
      out_tready <= 1'b0;
      hold_cnt   <= hold_cnt + 1;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_r.accel_x        = out_tdata[AXIS_W-1:0];
      got_r.accel_y        = out_tdata[2*AXIS_W-1:AXIS_W];
      got_r.accel_z        = out_tdata[3*AXIS_W-1:2*AXIS_W];
      got_r.magnitude      = out_tdata[3*AXIS_W+MAG_W-1:3*AXIS_W];
      got_r.over_threshold = out_tuser[0];
      got_r.batch_impact   = out_tuser[1];
      got_r.last_flag      = out_tlast;
      result_cnt++;
      if (got_r.last_flag) batch_cnt++;
      if (got_r.batch_impact) impact_cnt++;
      if (result_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected result: x=%0d y=%0d z=%0d mag=%0d", got_r.accel_x,
                   got_r.accel_y, got_r.accel_z, got_r.magnitude);
      end else begin
        want_r = result_q.pop_front();
        if (got_r.accel_x !== want_r.accel_x || got_r.accel_y !== want_r.accel_y ||
            got_r.accel_z !== want_r.accel_z || got_r.magnitude !== want_r.magnitude ||
            got_r.over_threshold !== want_r.over_threshold ||
            got_r.batch_impact !== want_r.batch_impact ||
            got_r.last_flag !== want_r.last_flag) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("mismatch on result %0d:", result_cnt);
            $display("  expected x=%0d y=%0d z=%0d mag=%0d over=%0b batch=%0b last=%0b",
                     want_r.accel_x, want_r.accel_y, want_r.accel_z, want_r.magnitude,
                     want_r.over_threshold, want_r.batch_impact, want_r.last_flag);
            $display("  actual   x=%0d y=%0d z=%0d mag=%0d over=%0b batch=%0b last=%0b",
                     got_r.accel_x, got_r.accel_y, got_r.accel_z, got_r.magnitude,
                     got_r.over_threshold, got_r.batch_impact, got_r.last_flag);
          end
        end
      end
    end
  end

  // Ends a run that has stopped making progress on every channel.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("no progress for %0d cycles", STALL_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int unsigned res, scl, thr, typical;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Register defaults: extremes, a threshold straddle and batch flag clearing.
    sample_q.push_back(make_sample(0, 0, 0, 1'b0));
    sample_q.push_back(make_sample(32767, 32767, 32767, 1'b0));
    sample_q.push_back(make_sample(-32768, -32768, -32768, 1'b1));
    sample_q.push_back(make_sample(-1, 1, 0, 1'b1));
    sample_q.push_back(make_sample(42 << 6, 0, 0, 1'b0));
    sample_q.push_back(make_sample(41 << 6, 0, 0, 1'b1));
    sample_q.push_back(make_sample(0, -(41 << 6), 0, 1'b1));
    sample_q.push_back(make_sample(0, 0, 42 << 6, 1'b1));
    wait_idle();

    // Resolution above range acts as the highest; largest scale and threshold.
    apply_settings(15, 255, (1 << THR_W) - 1);
    sample_q.push_back(make_sample(-32768, -32768, -32768, 1'b0));
    sample_q.push_back(make_sample(32767, -32768, 32767, 1'b1));
    sample_q.push_back(make_sample(-16, 15, 16, 1'b0));
    wait_idle();

    // Unknown register is ignored; zero scale; resolution below range.
    write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
    apply_settings(0, 0, 0);
    sample_q.push_back(make_sample(32767, -32768, 1234, 1'b0));
    sample_q.push_back(make_sample(-32768, 32767, -1, 1'b1));
    wait_idle();
    apply_settings(7, 1, 0);
    sample_q.push_back(make_sample(256, 0, 0, 1'b1));
    sample_q.push_back(make_sample(255, 0, 0, 1'b1));
    wait_idle();
    apply_settings(13, 1, 1);
    sample_q.push_back(make_sample(16, 16, 0, 1'b1));
    sample_q.push_back(make_sample(-17, 0, 0, 1'b1));
    wait_idle();

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p < 3) begin
        send_idle_pct  = 10;
        recv_stall_pct = 80;
      end else if (p < 6) begin
        send_idle_pct  = 80;
        recv_stall_pct = 10;
      end else begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      if (p == 0) begin
        apply_settings(RES_MIN, 1, 0);
      end else if (p == 1) begin
        apply_settings(RES_MAX, 255, (1 << THR_W) - 1);
      end else begin
        res     = ($urandom_range(0, 9) < 7) ? $urandom_range(RES_MIN, RES_MAX)
                                             : $urandom_range(0, 15);
        scl     = $urandom_range(0, 255);
        typical = scl * (1 << (clamp_res(res[RES_W-1:0]) - 1));
        thr     = ($urandom_range(0, 4) == 0) ? $urandom_range(0, (1 << THR_W) - 1)
                                              : $urandom_range(0, typical);
        if (p % 3 == 0) write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
        apply_settings(res, scl, thr);
      end
      @(negedge clk);
      // With the sender never idle, a long receiver hold-off backs the block up.
      if (p == 6) hold_armed = 1'b1;
      for (int k = 0; k < PHASE_ITEMS; k++) sample_q.push_back(rand_sample());
      wait_idle();
    end

    while (result_q.size() != 0) begin
      want_r = result_q.pop_front();
      mismatch_cnt++;
      if (mismatch_cnt <= 10)
        $display("missing result: x=%0d y=%0d z=%0d mag=%0d", want_r.accel_x,
                 want_r.accel_y, want_r.accel_z, want_r.magnitude);
    end

    $display("Checked %0d samples against %0d results over %0d register settings",
             sample_cnt, result_cnt, setting_cnt);
    $display("(%0d register writes); %0d batches closed, %0d reported an impact.",
             cfg_writes, batch_cnt, impact_cnt);
    if (mismatch_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d failures", mismatch_cnt);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/aimd_pkg.sv
sv/aimd_ctrl.sv
sv/aimd_dp.sv
sv/accel_impact_magnitude_detector.sv
dv/accel_impact_magnitude_detector_tb.sv
